>>> rtl/drt_pkg.sv
package drt_pkg;

    // Field widths of the item payloads
    localparam int CMD_W        = 2;
    localparam int COORD_W      = 16;
    localparam int EDGE_W       = 18;
    localparam int EXTENT_W     = 17;
    localparam int READ_IDX_W   = 4;
    localparam int RECT_COUNT_W = 5;

    // Bus widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    localparam int MAX_ENTRIES_DEFAULT = 16;

    // Command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // One table entry: left/top edges and exclusive right/bottom edges
    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [EDGE_W-1:0]  right;
        logic [EDGE_W-1:0]  bottom;
    } rect_t;

    function automatic logic signed [EDGE_W-1:0] sx18(input logic [COORD_W-1:0] v);
        sx18 = $signed({{(EDGE_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

endpackage

>>> rtl/drt_ram.sv
module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/drt_rect_unit.sv
module drt_rect_unit (
    input  drt_pkg::rect_t                  entry,
    input  drt_pkg::rect_t                  mark,
    output logic                            touch,
    output drt_pkg::rect_t                  union_rect,
    output logic [drt_pkg::EXTENT_W-1:0]    entry_width,
    output logic [drt_pkg::EXTENT_W-1:0]    entry_height
);
    import drt_pkg::*;

    logic signed [EDGE_W-1:0] e_l, e_t, m_l, m_t;
    logic signed [EDGE_W-1:0] w_diff, h_diff;

    assign e_l = sx18(entry.left);
    assign e_t = sx18(entry.top);
    assign m_l = sx18(mark.left);
    assign m_t = sx18(mark.top);

    // Touching edges count as overlap
    assign touch = !(($signed(entry.right) < m_l) || ($signed(mark.right) < e_l) ||
                     ($signed(entry.bottom) < m_t) || ($signed(mark.bottom) < e_t));

    always_comb begin
        union_rect.left   = (e_l < m_l) ? entry.left : mark.left;
        union_rect.top    = (e_t < m_t) ? entry.top : mark.top;
        union_rect.right  = ($signed(entry.right) > $signed(mark.right)) ?
                            entry.right : mark.right;
        union_rect.bottom = ($signed(entry.bottom) > $signed(mark.bottom)) ?
                            entry.bottom : mark.bottom;
    end

    assign w_diff       = $signed(entry.right) - e_l;
    assign h_diff       = $signed(entry.bottom) - e_t;
    assign entry_width  = w_diff[EXTENT_W-1:0];
    assign entry_height = h_diff[EXTENT_W-1:0];

endmodule

>>> rtl/dirty_rectangle_tracker_core.sv
// Path from input accept to m_tvalid: PREP, then FINISH for clear, unused command, empty mark,
// a read at or beyond the count and a mark into an empty table; PREP, READ, FINISH for a read
// that hits; PREP, SCAN, FINISH for a mark that scans the table, at most MAX_ENTRIES entries,
// and the scan reads one entry per cycle through the shared rectangle unit. No new item is taken
// until the last one has reached the output register; s_tready is high only while idle.
// Reset (aresetn low, synchronous) empties the table count and drops m_tvalid; no clear pass.
module dirty_rectangle_tracker_core #(
    parameter int MAX_ENTRIES = drt_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input item
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] size_w, [63:48] size_h,
    // [67:64] read_index, [71:68] zero padding
    input  logic [drt_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [drt_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] rect_left, [31:16] rect_top, [48:32] rect_width, [65:49] rect_height,
    // [70:66] rect_count, [71] any_dirty
    output logic [drt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import drt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [COORD_W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0]     w_reg, w_next, h_reg, h_next;
    logic [READ_IDX_W-1:0]  ridx_reg, ridx_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [COORD_W-1:0]     res_left_reg, res_left_next, res_top_reg, res_top_next;
    logic [EXTENT_W-1:0]    res_width_reg, res_width_next, res_height_reg, res_height_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Table RAM and rectangle unit
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    rect_t                  wr_data;
    logic [$bits(rect_t)-1:0] rd_word;
    rect_t                  entry_rd, mark_rect, union_rect;
    logic                   touch;
    logic [EXTENT_W-1:0]    ent_width, ent_height;

    logic                   empty_mark;
    logic                   last_entry;
    logic                   read_hit;

    // Address with idx_next so that rd_word shows the entry at idx_reg
    drt_ram #(
        .WIDTH ($bits(rect_t)),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(idx_next),
        .rd_data(rd_word)
    );

    assign entry_rd = rect_t'(rd_word);

    // Rectangle being marked, with exclusive right and bottom edges
    always_comb begin
        mark_rect.left   = x_reg;
        mark_rect.top    = y_reg;
        mark_rect.right  = sx18(x_reg) + sx18(w_reg);
        mark_rect.bottom = sx18(y_reg) + sx18(h_reg);
    end

    drt_rect_unit u_rect (
        .entry       (entry_rd),
        .mark        (mark_rect),
        .touch       (touch),
        .union_rect  (union_rect),
        .entry_width (ent_width),
        .entry_height(ent_height)
    );

    assign empty_mark = w_reg[COORD_W-1] || (w_reg == '0) ||
                        h_reg[COORD_W-1] || (h_reg == '0);
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign read_hit   = CMP_W'(ridx_reg) < CMP_W'(count_reg);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        ridx_next       = ridx_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_left_next   = res_left_reg;
        res_top_next    = res_top_reg;
        res_width_next  = res_width_reg;
        res_height_next = res_height_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = union_rect;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[CMD_W-1:0];
                    x_next     = s_tdata[15:0];
                    y_next     = s_tdata[31:16];
                    w_next     = s_tdata[47:32];
                    h_next     = s_tdata[63:48];
                    ridx_next  = s_tdata[67:64];
                    idx_next   = '0;
                    state_next = ST_PREP;
                end
            end

            ST_PREP: begin
                res_left_next   = '0;
                res_top_next    = '0;
                res_width_next  = '0;
                res_height_next = '0;
                state_next      = ST_FINISH;
                unique case (cmd_reg)
                    CMD_MARK: begin
                        if (!empty_mark) begin
                            if (count_reg == '0) begin
                                // Empty table: append at entry 0 at once
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = mark_rect;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        count_next = '0;
                    end
                    CMD_READ: begin
                        if (read_hit) begin
                            idx_next   = IDX_W'(ridx_reg);
                            state_next = ST_READ;
                        end
                    end
                    CMD_NONE: begin
                        state_next = ST_FINISH;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_SCAN: begin
                if (touch) begin
                    // First overlapping entry takes the bounding union
                    wr_en      = 1'b1;
                    state_next = ST_FINISH;
                end else if (last_entry) begin
                    wr_en      = 1'b1;
                    state_next = ST_FINISH;
                    if (count_reg < FULL_COUNT) begin
                        wr_addr    = IDX_W'(count_reg);
                        wr_data    = mark_rect;
                        count_next = count_reg + CNT_W'(1);
                    end
                    // Full table: union goes into the last entry, which is idx_reg here
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_READ: begin
                res_left_next   = entry_rd.left;
                res_top_next    = entry_rd.top;
                res_width_next  = ent_width;
                res_height_next = ent_height;
                state_next      = ST_FINISH;
            end

            ST_FINISH: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {(count_reg != '0), RECT_COUNT_W'(count_reg),
                                     res_height_reg, res_width_reg,
                                     res_top_reg, res_left_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        ridx_reg       <= ridx_next;
        res_left_reg   <= res_left_next;
        res_top_reg    <= res_top_next;
        res_width_reg  <= res_width_next;
        res_height_reg <= res_height_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/drt_checker.sv
module drt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [drt_pkg::M_TDATA_W-1:0] m_tdata
);

    // Reset leaves the block idle with no result pending
    assert property (@(posedge aclk) !aresetn |=> (!m_tvalid && s_tready))
        else $error("reset did not return to idle");

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // A new result only appears at the end of a busy stretch
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result issued without work in progress");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind dirty_rectangle_tracker_core drt_checker u_drt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> tb/dirty_rectangle_tracker_core_tb.sv
module dirty_rectangle_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drt_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;

    // Result item as it appears on m_tdata, most significant field first
    typedef struct packed {
        logic        dirty;
        logic [4:0]  count;
        logic [16:0] height;
        logic [16:0] width;
        logic [15:0] top;
        logic [15:0] left;
    } rect_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // pos_x, pos_y, size_w, size_h, read_index, padding
    logic [S_TUSER_W-1:0] s_tuser;   // command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // rect_left, rect_top, rect_width, rect_height,
                                     // rect_count, any_dirty

    dirty_rectangle_tracker_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the rectangle table; edges and sizes kept as plain integers
    int tbl_left   [TABLE_DEPTH];
    int tbl_top    [TABLE_DEPTH];
    int tbl_width  [TABLE_DEPTH];
    int tbl_height [TABLE_DEPTH];
    int tbl_count;

    rect_result_t expected_rects[$];

    int  errors;
    int  items_sent;
    int  results_seen;
    bit  send_gaps_on;
    bit  ready_stalls_on;
    int  stall_left;

    // Coverage tallies for the closing summary
    int  n_marks, n_empty_marks, n_appends, n_merges, n_full_merges;
    int  n_reads_hit, n_reads_miss, n_clears, n_unused;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Grow entry k to the bounding box of itself and the new rectangle
    function automatic void merge_entry(int k, int x, int y, int w, int h);
        int l, t, r, b;
        l = (tbl_left[k] < x) ? tbl_left[k] : x;
        t = (tbl_top[k] < y) ? tbl_top[k] : y;
        r = tbl_left[k] + tbl_width[k];
        if (x + w > r) r = x + w;
        b = tbl_top[k] + tbl_height[k];
        if (y + h > b) b = y + h;
        tbl_left[k]   = l;
        tbl_top[k]    = t;
        tbl_width[k]  = r - l;
        tbl_height[k] = b - t;
    endfunction

    // Advance the shadow table by one command and return the result it must produce
    function automatic rect_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic signed [15:0] px,
                                                   logic signed [15:0] py,
                                                   logic signed [15:0] sw,
                                                   logic signed [15:0] sh,
                                                   logic [3:0] idx);
        rect_result_t r;
        int x, y, w, h, i;
        bit hit;
        r = '0;
        x = px;
        y = py;
        w = sw;
        h = sh;
        case (cmd)
            CMD_MARK: begin
                n_marks++;
                if (w <= 0 || h <= 0) begin
                    // empty rectangle: leave the table alone
                    n_empty_marks++;
                end else begin
                    hit = 1'b0;
                    for (i = 0; i < tbl_count && !hit; i++) begin
                        // touching edges count as overlap
                        if (!(tbl_left[i] + tbl_width[i] < x || x + w < tbl_left[i] ||
                              tbl_top[i] + tbl_height[i] < y || y + h < tbl_top[i])) begin
                            merge_entry(i, x, y, w, h);
                            hit = 1'b1;
                            n_merges++;
                        end
                    end
                    if (!hit) begin
                        if (tbl_count < TABLE_DEPTH) begin
                            tbl_left[tbl_count]   = x;
                            tbl_top[tbl_count]    = y;
                            tbl_width[tbl_count]  = w;
                            tbl_height[tbl_count] = h;
                            tbl_count++;
                            n_appends++;
                        end else begin
                            // full table: fold into the last entry
                            merge_entry(TABLE_DEPTH - 1, x, y, w, h);
                            n_full_merges++;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
                n_clears++;
            end
            CMD_READ: begin
                if (idx < tbl_count) begin
                    r.left   = tbl_left[idx][15:0];
                    r.top    = tbl_top[idx][15:0];
                    r.width  = tbl_width[idx][16:0];
                    r.height = tbl_height[idx][16:0];
                    n_reads_hit++;
                end else begin
                    n_reads_miss++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        r.count = tbl_count[4:0];
        r.dirty = (tbl_count > 0);
        return r;
    endfunction

    // Present one item, hold it until accepted, and log what it must return
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [15:0] px, logic [15:0] py,
                             logic [15:0] sw, logic [15:0] sh, logic [3:0] idx);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, idx, sh, sw, py, px};
        s_tuser  = cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_rects.push_back(apply_command(cmd, px, py, sw, sh, idx));
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_mark(logic [15:0] px, logic [15:0] py, logic [15:0] sw,
                             logic [15:0] sh);
        send_item(CMD_MARK, px, py, sw, sh, 4'd0);
    endtask

    task automatic send_read(logic [3:0] idx);
        send_item(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, idx);
    endtask

    // Drop m_tready in random bursts while stalls are on
    always @(negedge aclk) begin
        if (stall_left == 0 && ready_stalls_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        m_tready = (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        rect_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (expected_rects.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = expected_rects.pop_front();
                if (got.left !== want.left) begin
                    $error("rect_left: expected %0d, got %0d",
                           $signed(want.left), $signed(got.left));
                    errors++;
                end
                if (got.top !== want.top) begin
                    $error("rect_top: expected %0d, got %0d",
                           $signed(want.top), $signed(got.top));
                    errors++;
                end
                if (got.width !== want.width) begin
                    $error("rect_width: expected %0d, got %0d", want.width, got.width);
                    errors++;
                end
                if (got.height !== want.height) begin
                    $error("rect_height: expected %0d, got %0d", want.height, got.height);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("rect_count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
                if (got.dirty !== want.dirty) begin
                    $error("any_dirty: expected %0d, got %0d", want.dirty, got.dirty);
                    errors++;
                end
            end
        end
    end

    // Empty table reads, ignored marks, the unused command and a read at the count
    task automatic test_empty_and_ignored();
        send_read(4'd0);
        send_read(4'd15);
        send_mark(16'd10, 16'd10, 16'd0, 16'd5);               // zero width
        send_mark(16'd10, 16'd10, 16'd5, 16'd0);               // zero height
        send_mark(16'd10, 16'd10, 16'h8000, 16'd5);            // most negative width
        send_mark(16'd10, 16'd10, 16'd5, 16'hFFFF);            // negative height
        send_item(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 4'hF);
        send_mark(16'd0, 16'd0, 16'd10, 16'd10);
        send_item(CMD_NONE, 16'd0, 16'd0, 16'd1, 16'd1, 4'd0);
        send_read(4'd1);                                       // at count: zeros
    endtask

    // Shared edges merge, a gap does not
    task automatic test_touching_edges();
        send_mark(16'd10, 16'd0, 16'd5, 16'd5);                // right edge touches
        send_mark(16'd0, 16'd16, 16'd4, 16'd4);                // six rows below entry 0: apart
        send_mark(16'd4, 16'd15, 16'd2, 16'd2);                // touches entry 1 only
        send_read(4'd0);
        send_read(4'd1);
        send_item(CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0);
        send_read(4'd0);
    endtask

    // Coordinate extremes, up to the widest union the table can hold
    task automatic test_coordinate_extremes();
        send_mark(16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
        send_mark(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);     // corner touch: 65534 wide
        send_mark(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);     // ends at -1: apart
        send_mark(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);           // bridges into entry 0
        send_mark(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);     // widest: 98302
        send_read(4'd0);
        send_read(4'd1);
        send_read(4'd2);
    endtask

    // Lay out from two fewer to four more disjoint cells than the table holds, then probe it
    task automatic fill_grid_sequence();
        int i, n, base_x, base_y;
        base_x = $urandom_range(0, 20000) - 10000;
        base_y = $urandom_range(0, 20000) - 10000;
        n = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4);
        send_item(CMD_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0);
        for (i = 0; i < n; i++)
            send_mark(16'(base_x + (i % 4) * 200), 16'(base_y + (i / 4) * 200),
                      16'($urandom_range(1, 120)), 16'($urandom_range(1, 120)));
        repeat ($urandom_range(2, 6)) send_read(4'($urandom_range(0, 15)));
    endtask

    task automatic send_random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 48)
            send_mark(16'($urandom_range(0, 1500) - 750), 16'($urandom_range(0, 1500) - 750),
                      16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
        else if (sel < 54)
            send_mark(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (sel < 58)
            send_mark(16'(16'h7FFF - $urandom_range(0, 200)),
                      16'(16'h8000 + $urandom_range(0, 200)),
                      16'($urandom_range(1, 32767)), 16'($urandom_range(1, 32767)));
        else if (sel < 60)
            send_mark(16'($urandom), 16'($urandom), 16'(-$urandom_range(0, 32768)),
                      16'($urandom));
        else if (sel < 93)
            send_read(4'($urandom_range(0, 15)));
        else if (sel < 96)
            send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom));
        else
            send_item(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom));
    endtask

    // Random traffic in blocks; every fourth block runs with no idling at all
    task automatic test_random_traffic();
        int blk;
        blk = 0;
        while (items_sent < 900) begin
            send_gaps_on    = (blk % 4 != 3);
            ready_stalls_on = (blk % 4 != 3);
            if ($urandom_range(0, 3) == 0)
                fill_grid_sequence();
            else
                repeat (40) send_random_item();
            blk++;
        end
    endtask

    // Back-to-back tail with both sides always ready
    task automatic test_full_rate_tail();
        send_gaps_on    = 1'b0;
        ready_stalls_on = 1'b0;
        repeat (100) send_random_item();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_MARK;
        m_tready        = 1'b0;
        aclk            = 1'b0;
        tbl_count       = 0;
        errors          = 0;
        items_sent      = 0;
        results_seen    = 0;
        stall_left      = 0;
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_and_ignored();
        test_touching_edges();
        test_coordinate_extremes();
        test_random_traffic();
        test_full_rate_tail();

        // Drain outstanding results, then allow for the longest scan
        while (expected_rects.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d items, checked %0d results: %0d marks (%0d empty), %0d appends,",
                 items_sent, results_seen, n_marks, n_empty_marks, n_appends);
        $display("  %0d merges, %0d full-table merges, %0d/%0d reads hit/miss,",
                 n_merges, n_full_merges, n_reads_hit, n_reads_miss);
        $display("  %0d clears, %0d unused", n_clears, n_unused);
        if (errors == 0 && expected_rects.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/drt_pkg.sv
rtl/drt_ram.sv
rtl/drt_rect_unit.sv
rtl/dirty_rectangle_tracker_core.sv
rtl/drt_checker.sv
tb/dirty_rectangle_tracker_core_tb.sv
